FILE: rtl/pfra_pkg.sv
// Shared constants and types for the page frame reference count allocator.
package pfra_pkg;

  localparam int unsigned PagesDefault     = 4096;
  localparam int unsigned CountBitsDefault = 8;

  localparam int unsigned PageW     = 12;
  localparam int unsigned IndexW    = 13;
  localparam int unsigned CfgW      = 13;
  localparam int unsigned NewCountW = 8;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 24;

  typedef enum logic [1:0] {
    ModeAlloc = 2'd0,
    ModeRef   = 2'd1,
    ModeInit  = 2'd2,
    ModeNone  = 2'd3
  } mode_e;

  typedef enum logic {
    CfgPageCount = 1'b0,
    CfgReserved  = 1'b1
  } cfg_idx_e;

endpackage

FILE: rtl/page_frame_refcount_allocator.sv
// Page frame reference count table with first-fit allocation, top level.
//
// The frame table lives in one synchronous memory of PAGES entries of COUNT_BITS
// each. After reset the block clears the table, one entry per cycle, before it
// takes the first beat; configuration writes are taken during that time. One
// request is worked on at a time. An allocate beat scans the frames of its range,
// reading one memory entry per cycle; an allocate beat with an empty range does
// not scan. A reference beat reads, modifies and writes the entry.
// An initialize beat does one memory write per frame for max(reserved, installed)
// frames. The result register lets the next request be accepted while the
// previous result still waits to be taken.
module page_frame_refcount_allocator
  import pfra_pkg::*;
#(
  parameter int unsigned PAGES      = PagesDefault,
  parameter int unsigned COUNT_BITS = CountBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // Fields from bit 0: mode[1:0], lower_page[11:0], upper_page[11:0], page[11:0].
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // Fields from bit 0: page_index[12:0], found, new_count[7:0].
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned AW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam logic [IndexW-1:0] UpperMax =
      (PAGES > 4096) ? IndexW'(4095) : IndexW'(PAGES - 1);
  localparam logic [CfgW-1:0] CfgMax =
      (PAGES > 8191) ? CfgW'(8191) : CfgW'(PAGES);
  localparam logic [AW-1:0] LastAddr = AW'(PAGES - 1);
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CountOne = COUNT_BITS'(1);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StScan,
    StRefWr,
    StInit,
    StDone
  } state_e;

  state_e              state_q;
  logic [AW-1:0]       clr_q;
  logic [IndexW-1:0]   issue_q;
  logic [IndexW-1:0]   end_q;
  logic                pend_vld_q;
  logic [IndexW-1:0]   pend_idx_q;
  logic [PageW-1:0]    ref_page_q;
  logic                ref_ok_q;
  logic [CfgW-1:0]     rsv_q;
  logic [CfgW-1:0]     page_count_q;
  logic [CfgW-1:0]     reserved_q;
  logic [IndexW-1:0]   res_index_q;
  logic                res_found_q;
  logic [NewCountW-1:0] res_count_q;
  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;

  logic [COUNT_BITS-1:0] mem [PAGES];
  logic [COUNT_BITS-1:0] rdata_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;

  mode_e             in_mode;
  logic [PageW-1:0]  in_lower;
  logic [PageW-1:0]  in_upper;
  logic [PageW-1:0]  in_page;
  logic [IndexW-1:0] upper_c;
  logic [CfgW-1:0]   rsv_c;
  logic [CfgW-1:0]   top_c;
  logic [CfgW-1:0]   init_end;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic              out_free;
  logic              in_acc;

  assign in_mode  = mode_e'(s_axis_tdata[1:0]);
  assign in_lower = s_axis_tdata[13:2];
  assign in_upper = s_axis_tdata[25:14];
  assign in_page  = s_axis_tdata[37:26];

  assign upper_c  = ({1'b0, in_upper} > UpperMax) ? UpperMax : {1'b0, in_upper};
  assign rsv_c    = (reserved_q > CfgMax) ? CfgMax : reserved_q;
  assign top_c    = (page_count_q > CfgMax) ? CfgMax : page_count_q;
  assign init_end = (rsv_c > top_c) ? rsv_c : top_c;
  assign cnt_inc  = (rdata_q == CountMax) ? rdata_q : rdata_q + CountOne;

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '0;
    mem_raddr = AW'(in_page);
    case (state_q)
      StClear: begin
        mem_we = 1'b1;
      end
      StInit: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(issue_q);
        mem_wdata = (issue_q < rsv_q) ? CountOne : '0;
      end
      StRefWr: begin
        mem_we    = ref_ok_q;
        mem_waddr = AW'(ref_page_q);
        mem_wdata = cnt_inc;
      end
      StScan: begin
        mem_raddr = AW'(issue_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_count_q <= CfgW'(4096);
      reserved_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgPageCount: page_count_q <= cfg_wdata_i;
        CfgReserved:  reserved_q   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      clr_q      <= '0;
      pend_vld_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        StClear: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == LastAddr) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (in_acc) begin
            res_index_q <= '0;
            res_found_q <= 1'b0;
            res_count_q <= '0;
            pend_vld_q  <= 1'b0;
            state_q     <= StDone;
            case (in_mode)
              ModeAlloc: begin
                res_index_q <= upper_c + IndexW'(1);
                issue_q     <= {1'b0, in_lower};
                end_q       <= upper_c;
                if ({1'b0, in_lower} <= upper_c) begin
                  state_q <= StScan;
                end
              end
              ModeRef: begin
                ref_page_q <= in_page;
                ref_ok_q   <= (32'(in_page) < PAGES);
                state_q    <= StRefWr;
              end
              ModeInit: begin
                rsv_q   <= rsv_c;
                end_q   <= init_end;
                issue_q <= '0;
                if (init_end != '0) begin
                  state_q <= StInit;
                end
              end
              default: begin
              end
            endcase
          end
        end
        StScan: begin
          issue_q    <= issue_q + IndexW'(1);
          pend_idx_q <= issue_q;
          pend_vld_q <= 1'b1;
          if (pend_vld_q) begin
            if (rdata_q == '0) begin
              res_index_q <= pend_idx_q;
              res_found_q <= 1'b1;
              state_q     <= StDone;
            end else if (pend_idx_q == end_q) begin
              state_q <= StDone;
            end
          end
        end
        StRefWr: begin
          if (ref_ok_q) begin
            res_count_q <= NewCountW'(cnt_inc);
          end
          state_q <= StDone;
        end
        StInit: begin
          issue_q <= issue_q + IndexW'(1);
          if (issue_q == end_q - IndexW'(1)) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {2'b00, res_count_q, res_found_q, res_index_q};
            state_q   <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule
